[hdl/assert_macros.svh]
// Assertion macros used by the top level of the tile store.
// Depends on nothing; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  `ASSERT_PROP(lbl, clk, rstn, (ante) |-> (cons))

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `ASSERT_PROP(lbl, clk, rstn, (ante) |=> (cons))

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/tsdr_pkg.sv]
// Package of the dirty-rectangle tile store: grid constants, command codes,
// transaction structs and the rectangle record. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsdr_pkg;

  // Grid geometry.
  localparam int CHUNK_SIZE = 64;
  localparam int CELL_COUNT = CHUNK_SIZE * CHUNK_SIZE;
  localparam int COORD_W    = $clog2(CHUNK_SIZE);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int DATA_W     = 32;
  localparam int RECT_W     = 6;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Command codes.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_FILL  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  // Input transaction.
  typedef struct packed {
    func_t              func;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic [DATA_W-1:0]  cell_value;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              rect_any;
    logic [RECT_W-1:0] rect_left;
    logic [RECT_W-1:0] rect_top;
    logic [RECT_W-1:0] rect_right;
    logic [RECT_W-1:0] rect_bottom;
  } out_t;

  // Dirty rectangle as held in the tracker.
  typedef struct packed {
    logic   any;
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  // Update request from the controller to the rectangle tracker.
  typedef struct packed {
    logic   wr;
    logic   fill;
    logic   clr;
    coord_t x;
    coord_t y;
  } rect_cmd_t;

  // Fit a grid coordinate into the result field, masking or zero extending.
  function automatic logic [RECT_W-1:0] to_rect_field(coord_t c);
    logic [RECT_W+COORD_W-1:0] wide;
    wide = {{RECT_W{1'b0}}, c};
    return wide[RECT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/tsdr_ram.sv]
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; the cell store of the tile buffer uses it.
`timescale 1ns / 1ps
`default_nettype none

module tsdr_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[hdl/tsdr_rect.sv]
// Dirty-rectangle tracker: holds the bounding box of written cells; a fill marks the whole grid, a clear empties it.
// Depends on tsdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsdr_rect
  import tsdr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rect_cmd_t cmd,
  output rect_t          rect_cur,
  output rect_t          rect_nxt
);

  rect_t rect_r;

  // Next rectangle for the current command.
  always_comb begin
    rect_nxt = rect_r;
    if (cmd.clr) begin
      rect_nxt = '0;
    end else if (cmd.fill) begin
      rect_nxt.any    = 1'b1;
      rect_nxt.left   = '0;
      rect_nxt.top    = '0;
      rect_nxt.right  = COORD_W'(CHUNK_SIZE - 1);
      rect_nxt.bottom = COORD_W'(CHUNK_SIZE - 1);
    end else if (cmd.wr) begin
      if (!rect_r.any) begin
        rect_nxt.any    = 1'b1;
        rect_nxt.left   = cmd.x;
        rect_nxt.right  = cmd.x;
        rect_nxt.top    = cmd.y;
        rect_nxt.bottom = cmd.y;
      end else begin
        if (cmd.x < rect_r.left)   rect_nxt.left   = cmd.x;
        if (cmd.x > rect_r.right)  rect_nxt.right  = cmd.x;
        if (cmd.y < rect_r.top)    rect_nxt.top    = cmd.y;
        if (cmd.y > rect_r.bottom) rect_nxt.bottom = cmd.y;
      end
    end
  end

  // Rectangle register; starts empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_r <= '0;
    end else begin
      rect_r <= rect_nxt;
    end
  end

  assign rect_cur = rect_r;

endmodule

`default_nettype wire

[hdl/tile_store_dirty_rect.sv]
// Top level of the dirty-rectangle tile store: command decode, fill sweep,
// result register. Depends on tsdr_pkg, tsdr_ram, tsdr_rect, assert_macros.svh.
//
// A command is taken when start is high and busy is low. Write, read and
// clear-dirty commands can follow one another in every cycle; each gives
// its result on out_item with out_strobe high in the cycle after it was
// taken, read data coming straight from the cell RAM.
// A fill writes the single RAM port once per cell, so it holds busy for
// the whole sweep over the grid and strobes its result in the cycle after
// the last cell is written. After reset the same sweep clears the RAM to
// zero with busy high, and no result is given. The receiver cannot stall:
// a result is present for exactly one cycle and must be captured then.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tile_store_dirty_rect
  import tsdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_strobe,
  output out_t      out_item
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_FILL  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  addr_t             sweep_r, sweep_nxt;
  logic [DATA_W-1:0] fill_val_r, fill_val_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  rect_t             out_rect_r, out_rect_nxt;

  logic              acc;
  logic              x_in, y_in, on_grid;
  coord_t            cx, cy;
  addr_t             cell_addr;
  logic              sweeping, sweep_last;
  logic              ram_we, ram_re;
  addr_t             ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  rect_cmd_t         rect_cmd;
  rect_t             rect_cur, rect_nxt;
  logic              acc_fill, acc_short, rect_fields_zero;

  // Transaction acceptance and coordinate decode.
  assign busy = (state_r != ST_IDLE);
  assign acc  = start && !busy;

  assign x_in    = !in_item.cell_x[15] && ($unsigned(in_item.cell_x) < 16'(CHUNK_SIZE));
  assign y_in    = !in_item.cell_y[15] && ($unsigned(in_item.cell_y) < 16'(CHUNK_SIZE));
  assign on_grid = x_in && y_in;
  assign cx      = in_item.cell_x[COORD_W-1:0];
  assign cy      = in_item.cell_y[COORD_W-1:0];
  assign cell_addr = ADDR_W'(ADDR_W'(cy) * ADDR_W'(CHUNK_SIZE)) + ADDR_W'(cx);

  // Sweep over every cell for fills and the clearing pass after reset.
  assign sweeping   = (state_r == ST_CLEAR) || (state_r == ST_FILL);
  assign sweep_last = (sweep_r == ADDR_W'(CELL_COUNT - 1));

  // RAM port selection.
  assign ram_we    = sweeping || (acc && (in_item.func == FUNC_WRITE) && on_grid);
  assign ram_re    = acc && (in_item.func == FUNC_READ) && on_grid;
  assign ram_addr  = sweeping ? sweep_r : cell_addr;
  assign ram_wdata = sweeping ? fill_val_r : in_item.cell_value;

  tsdr_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Rectangle tracker commands.
  always_comb begin
    rect_cmd      = '0;
    rect_cmd.wr   = acc && (in_item.func == FUNC_WRITE) && on_grid;
    rect_cmd.fill = acc && (in_item.func == FUNC_FILL);
    rect_cmd.clr  = acc && (in_item.func == FUNC_CLEAR);
    rect_cmd.x    = cx;
    rect_cmd.y    = cy;
  end

  tsdr_rect u_rect (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rect_cmd),
    .rect_cur (rect_cur),
    .rect_nxt (rect_nxt)
  );

  // Sequencer and result register.
  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    fill_val_nxt   = fill_val_r;
    out_strobe_nxt = 1'b0;
    rd_pend_nxt    = 1'b0;
    out_rect_nxt   = out_rect_r;
    case (state_r)
      ST_CLEAR, ST_FILL: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_last) begin
          state_nxt = ST_IDLE;
          sweep_nxt = '0;
          if (state_r == ST_FILL) begin
            out_strobe_nxt = 1'b1;
            out_rect_nxt   = rect_cur;
          end
        end
      end
      ST_IDLE: begin
        if (acc) begin
          if (in_item.func == FUNC_FILL) begin
            state_nxt    = ST_FILL;
            sweep_nxt    = '0;
            fill_val_nxt = in_item.cell_value;
          end else begin
            out_strobe_nxt = 1'b1;
            rd_pend_nxt    = (in_item.func == FUNC_READ) && on_grid;
            out_rect_nxt   = rect_nxt;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        sweep_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      sweep_r      <= '0;
      fill_val_r   <= '0;
      out_strobe_r <= 1'b0;
      rd_pend_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      fill_val_r   <= fill_val_nxt;
      out_strobe_r <= out_strobe_nxt;
      rd_pend_r    <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rect_r <= out_rect_nxt;
  end

  // Result ports.
  always_comb begin
    out_item             = '0;
    out_item.read_data   = rd_pend_r ? ram_rdata : '0;
    out_item.rect_any    = out_rect_r.any;
    out_item.rect_left   = to_rect_field(out_rect_r.left);
    out_item.rect_top    = to_rect_field(out_rect_r.top);
    out_item.rect_right  = to_rect_field(out_rect_r.right);
    out_item.rect_bottom = to_rect_field(out_rect_r.bottom);
  end

  assign out_strobe = out_strobe_r;

  // Terms used by the checks.
  assign acc_fill         = acc && (in_item.func == FUNC_FILL);
  assign acc_short        = acc && (in_item.func != FUNC_FILL);
  assign rect_fields_zero = (out_item.rect_left == '0) && (out_item.rect_top == '0) &&
                            (out_item.rect_right == '0) && (out_item.rect_bottom == '0);

  // Checks.
  `ASSERT_NEXT(a_single_cycle_result, clk, rst_n, acc_short, out_strobe)
  `ASSERT_NEXT(a_fill_holds_busy, clk, rst_n, acc_fill, busy && !out_strobe)
  `ASSERT_IMPL(a_no_result_in_clear, clk, rst_n, state_r == ST_CLEAR, !out_strobe)
  `ASSERT_IMPL(a_empty_rect_zero, clk, rst_n, out_strobe && !out_item.rect_any, rect_fields_zero)

endmodule

`default_nettype wire
